/* src/tplq_pkg.sv */
// ----------------------------------------------------------------------------
// tplq_pkg: shared types and constants for the tree path LCA query core
// Request codes, table entry layout, controller states and the command and
// status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package tplq_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int NODE_W        = 10;
    localparam int PAR_W         = 11;
    localparam int FUNC_W        = 2;

    localparam logic signed [PAR_W-1:0] NODE_NONE = -11'sd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_LCA  = 2'd1,
        FUNC_KTH  = 2'd2
    } t_func;

    typedef struct packed {
        logic signed [PAR_W-1:0] parent;
        logic [NODE_W-1:0]       head;
        logic [NODE_W-1:0]       depth;
        logic [NODE_W-1:0]       pos;
    } t_node_ent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DONE,
        S_LCA_RDU,
        S_LCA_RDV,
        S_LCA_CMP,
        S_LCA_HOP,
        S_K_RDS,
        S_K_RDT,
        S_K_RDX,
        S_K_DIST,
        S_K_CHK,
        S_K_HEAD,
        S_K_NEXT,
        S_K_POS,
        S_FAIL
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_LCA_RDU,
        DP_LCA_RDV,
        DP_LCA_CMP,
        DP_LCA_HOP,
        DP_K_RDS,
        DP_K_RDT,
        DP_K_RDX,
        DP_K_DIST,
        DP_K_CHK,
        DP_K_HEAD,
        DP_K_NEXT,
        DP_K_POS,
        DP_FAIL
    } t_dp_op;

    typedef struct packed {
        logic is_kth;
        logic uv_ok;
        logic hops_over;
        logic heads_eq;
        logic hv_ok;
        logic par_neg;
        logic dist_fail;
        logic hs_ok;
        logic k_break;
        logic pos_ok;
        logic s_ok;
    } t_dp_stat;

endpackage

/* src/tree_path_lca_query_core.sv */
// ----------------------------------------------------------------------------
// tree_path_lca_query_core: heavy-light decomposition LCA and path query core
// A load request writes the tables and leaves busy low. An LCA query climbs
// (read u, read v, compare heads, hop) until both nodes share a chain, then
// strobes its result; a k-th vertex query walks on from there. busy is high
// while a query runs; the next request is taken in the strobe cycle. Reset
// clears only the sequencer: tables hold garbage until loaded.
// ----------------------------------------------------------------------------
module tree_path_lca_query_core #(
    parameter int MAX_NODES = tplq_pkg::MAX_NODES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [tplq_pkg::FUNC_W-1:0]           i_func,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_a,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_b,
    input  logic [tplq_pkg::NODE_W-1:0]           i_step_count,
    input  logic signed [tplq_pkg::PAR_W-1:0]     i_parent_node,
    input  logic [tplq_pkg::NODE_W-1:0]           i_chain_head,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_depth,
    input  logic [tplq_pkg::NODE_W-1:0]           i_visit_position,
    output logic                                  o_result_valid,
    output logic signed [tplq_pkg::PAR_W-1:0]     o_result_node
);

    tplq_pkg::t_dp_op   cmd;
    tplq_pkg::t_dp_stat stat;

    tplq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_func         (i_func),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    tplq_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_step_count     (i_step_count),
        .i_parent_node    (i_parent_node),
        .i_chain_head     (i_chain_head),
        .i_node_depth     (i_node_depth),
        .i_visit_position (i_visit_position),
        .o_stat           (stat),
        .o_result_node    (o_result_node)
    );

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == tplq_pkg::FUNC_LCA || i_func == tplq_pkg::FUNC_KTH))
        |=> busy)
        else $error("accepted query did not raise busy");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == tplq_pkg::FUNC_LOAD) |=> !o_result_valid)
        else $error("load request produced a result");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed while busy");

endmodule

/* src/tplq_ctrl.sv */
// ----------------------------------------------------------------------------
// tplq_ctrl: query sequencer
// Accepts requests, walks the LCA chain climb and the k-th vertex climb one
// table read at a time and strobes the result.
// ----------------------------------------------------------------------------
module tplq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [tplq_pkg::FUNC_W-1:0]       i_func,
    input  tplq_pkg::t_dp_stat                i_stat,
    output tplq_pkg::t_dp_op                  o_cmd,
    output logic                              busy,
    output logic                              o_result_valid
);

    tplq_pkg::t_state r_state;
    tplq_pkg::t_state n_state;
    logic             accept;
    logic             is_query;

    assign accept   = start && !busy;
    assign is_query = (i_func == tplq_pkg::FUNC_LCA) || (i_func == tplq_pkg::FUNC_KTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tplq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tplq_pkg::S_IDLE, tplq_pkg::S_DONE: begin
                if (accept && is_query) begin
                    n_state = tplq_pkg::S_LCA_RDU;
                end else begin
                    n_state = tplq_pkg::S_IDLE;
                end
            end
            tplq_pkg::S_LCA_RDU: begin
                if (i_stat.hops_over || !i_stat.uv_ok) begin
                    n_state = tplq_pkg::S_FAIL;
                end else begin
                    n_state = tplq_pkg::S_LCA_RDV;
                end
            end
            tplq_pkg::S_LCA_RDV: n_state = tplq_pkg::S_LCA_CMP;
            tplq_pkg::S_LCA_CMP: begin
                if (i_stat.heads_eq) begin
                    n_state = i_stat.is_kth ? tplq_pkg::S_K_RDS : tplq_pkg::S_DONE;
                end else if (i_stat.hv_ok) begin
                    n_state = tplq_pkg::S_LCA_HOP;
                end else begin
                    n_state = tplq_pkg::S_FAIL;
                end
            end
            tplq_pkg::S_LCA_HOP: begin
                n_state = i_stat.par_neg ? tplq_pkg::S_FAIL : tplq_pkg::S_LCA_RDU;
            end
            tplq_pkg::S_K_RDS: n_state = tplq_pkg::S_K_RDT;
            tplq_pkg::S_K_RDT: n_state = tplq_pkg::S_K_RDX;
            tplq_pkg::S_K_RDX: n_state = tplq_pkg::S_K_DIST;
            tplq_pkg::S_K_DIST: begin
                n_state = i_stat.dist_fail ? tplq_pkg::S_FAIL : tplq_pkg::S_K_CHK;
            end
            tplq_pkg::S_K_CHK: begin
                if (i_stat.hops_over || !i_stat.hs_ok) begin
                    n_state = tplq_pkg::S_FAIL;
                end else begin
                    n_state = tplq_pkg::S_K_HEAD;
                end
            end
            tplq_pkg::S_K_HEAD: begin
                if (i_stat.k_break) begin
                    n_state = i_stat.pos_ok ? tplq_pkg::S_K_POS : tplq_pkg::S_FAIL;
                end else begin
                    n_state = i_stat.s_ok ? tplq_pkg::S_K_NEXT : tplq_pkg::S_FAIL;
                end
            end
            tplq_pkg::S_K_NEXT: n_state = tplq_pkg::S_K_CHK;
            tplq_pkg::S_K_POS:  n_state = tplq_pkg::S_DONE;
            tplq_pkg::S_FAIL:   n_state = tplq_pkg::S_DONE;
            default:            n_state = tplq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        o_cmd          = tplq_pkg::DP_NOP;
        unique case (r_state)
            tplq_pkg::S_IDLE, tplq_pkg::S_DONE: begin
                busy           = 1'b0;
                o_result_valid = (r_state == tplq_pkg::S_DONE);
                if (start && i_func == tplq_pkg::FUNC_LOAD) begin
                    o_cmd = tplq_pkg::DP_LOAD;
                end else if (start && is_query) begin
                    o_cmd = tplq_pkg::DP_START;
                end
            end
            tplq_pkg::S_LCA_RDU: o_cmd = tplq_pkg::DP_LCA_RDU;
            tplq_pkg::S_LCA_RDV: o_cmd = tplq_pkg::DP_LCA_RDV;
            tplq_pkg::S_LCA_CMP: o_cmd = tplq_pkg::DP_LCA_CMP;
            tplq_pkg::S_LCA_HOP: o_cmd = tplq_pkg::DP_LCA_HOP;
            tplq_pkg::S_K_RDS:   o_cmd = tplq_pkg::DP_K_RDS;
            tplq_pkg::S_K_RDT:   o_cmd = tplq_pkg::DP_K_RDT;
            tplq_pkg::S_K_RDX:   o_cmd = tplq_pkg::DP_K_RDX;
            tplq_pkg::S_K_DIST:  o_cmd = tplq_pkg::DP_K_DIST;
            tplq_pkg::S_K_CHK:   o_cmd = tplq_pkg::DP_K_CHK;
            tplq_pkg::S_K_HEAD:  o_cmd = tplq_pkg::DP_K_HEAD;
            tplq_pkg::S_K_NEXT:  o_cmd = tplq_pkg::DP_K_NEXT;
            tplq_pkg::S_K_POS:   o_cmd = tplq_pkg::DP_K_POS;
            tplq_pkg::S_FAIL:    o_cmd = tplq_pkg::DP_FAIL;
            default:             o_cmd = tplq_pkg::DP_NOP;
        endcase
    end

endmodule

/* src/tplq_dpath.sv */
// ----------------------------------------------------------------------------
// tplq_dpath: tables and working registers of the query engine
// Holds the per-node table and the position-to-node table, one registered
// read port each, and the node, step and hop registers of the climb.
// ----------------------------------------------------------------------------
module tplq_dpath #(
    parameter int MAX_NODES = tplq_pkg::MAX_NODES_DEF
) (
    input  logic                                  i_clk,
    input  tplq_pkg::t_dp_op                      i_cmd,
    input  logic [tplq_pkg::FUNC_W-1:0]           i_func,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_a,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_b,
    input  logic [tplq_pkg::NODE_W-1:0]           i_step_count,
    input  logic signed [tplq_pkg::PAR_W-1:0]     i_parent_node,
    input  logic [tplq_pkg::NODE_W-1:0]           i_chain_head,
    input  logic [tplq_pkg::NODE_W-1:0]           i_node_depth,
    input  logic [tplq_pkg::NODE_W-1:0]           i_visit_position,
    output tplq_pkg::t_dp_stat                    o_stat,
    output logic signed [tplq_pkg::PAR_W-1:0]     o_result_node
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int HW = $clog2(MAX_NODES + 2);
    // step count can grow by one depth per hop on a malformed table
    localparam int KW = HW + tplq_pkg::NODE_W + 2;
    localparam logic signed [KW-1:0] K_ONE = KW'(1);

    localparam int NW = tplq_pkg::NODE_W;

    tplq_pkg::t_node_ent r_node_mem [MAX_NODES];
    logic [NW-1:0]       r_pos_mem  [MAX_NODES];
    tplq_pkg::t_node_ent r_node_q;
    logic [NW-1:0]       r_pos_q;

    logic                     r_kth;
    logic [NW-1:0]            r_a;
    logic [NW-1:0]            r_b;
    logic [NW-1:0]            r_u;
    logic [NW-1:0]            r_v;
    logic [NW-1:0]            r_lca;
    logic signed [KW-1:0]     r_k;
    logic [HW-1:0]            r_hops;
    tplq_pkg::t_node_ent      r_ent_u;
    tplq_pkg::t_node_ent      r_ent_s;
    tplq_pkg::t_node_ent      r_ent_t;
    logic signed [tplq_pkg::PAR_W-1:0] r_res;

    tplq_pkg::t_node_ent w_ent;
    logic [AW-1:0]       node_ra;
    logic [AW-1:0]       pos_ra;
    logic                swap;
    logic [NW-1:0]       early_node;
    tplq_pkg::t_node_ent late_ent;
    logic signed [KW-1:0] path_len;
    logic signed [KW-1:0] s_up;
    logic signed [KW-1:0] diff;
    logic signed [KW-1:0] pos_k;

    function automatic logic in_rng(input logic [NW-1:0] n);
        return 32'(n) < MAX_NODES;
    endfunction

    function automatic logic signed [KW-1:0] sx(input logic [NW-1:0] n);
        return $signed(KW'(n));
    endfunction

    assign w_ent = '{parent: i_parent_node, head: i_chain_head,
                     depth: i_node_depth, pos: i_visit_position};

    // LCA compare: r_ent_u is node u, r_node_q is node v
    assign swap       = r_ent_u.pos > r_node_q.pos;
    assign early_node = swap ? r_v : r_u;
    assign late_ent   = swap ? r_ent_u : r_node_q;

    assign path_len = sx(r_ent_s.depth) + sx(r_ent_t.depth) - (sx(r_node_q.depth) <<< 1);
    assign s_up     = sx(r_ent_s.depth) - sx(r_node_q.depth);
    assign diff     = s_up;
    assign pos_k    = sx(r_ent_s.pos) - r_k;

    always_comb begin
        o_stat           = '0;
        o_stat.is_kth    = r_kth;
        o_stat.uv_ok     = in_rng(r_u) && in_rng(r_v);
        o_stat.hops_over = 32'(r_hops) > MAX_NODES;
        o_stat.heads_eq  = r_ent_u.head == r_node_q.head;
        o_stat.hv_ok     = in_rng(late_ent.head);
        o_stat.par_neg   = r_node_q.parent[tplq_pkg::PAR_W-1];
        o_stat.dist_fail = path_len < r_k;
        o_stat.hs_ok     = in_rng(r_ent_s.head);
        o_stat.k_break   = diff >= r_k;
        o_stat.pos_ok    = (pos_k >= 0) && (pos_k < MAX_NODES);
        o_stat.s_ok      = !r_node_q.parent[tplq_pkg::PAR_W-1] && in_rng(r_node_q.parent[NW-1:0]);
    end

    always_comb begin
        unique case (i_cmd)
            tplq_pkg::DP_LCA_RDU: node_ra = AW'(r_u);
            tplq_pkg::DP_LCA_RDV: node_ra = AW'(r_v);
            tplq_pkg::DP_LCA_CMP: node_ra = AW'(late_ent.head);
            tplq_pkg::DP_K_RDS:   node_ra = AW'(r_a);
            tplq_pkg::DP_K_RDT:   node_ra = AW'(r_b);
            tplq_pkg::DP_K_RDX:   node_ra = AW'(r_lca);
            tplq_pkg::DP_K_CHK:   node_ra = AW'(r_ent_s.head);
            tplq_pkg::DP_K_HEAD:  node_ra = AW'(r_node_q.parent[NW-1:0]);
            default:              node_ra = '0;
        endcase
    end

    assign pos_ra = AW'(pos_k);

    always_ff @(posedge i_clk) begin
        if (i_cmd == tplq_pkg::DP_LOAD && in_rng(i_node_a)) begin
            r_node_mem[AW'(i_node_a)] <= w_ent;
        end
        r_node_q <= r_node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == tplq_pkg::DP_LOAD && in_rng(i_visit_position)) begin
            r_pos_mem[AW'(i_visit_position)] <= i_node_a;
        end
        r_pos_q <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            tplq_pkg::DP_START: begin
                r_kth  <= (i_func == tplq_pkg::FUNC_KTH);
                r_a    <= i_node_a;
                r_b    <= i_node_b;
                r_u    <= i_node_a;
                r_v    <= i_node_b;
                r_k    <= sx(i_step_count);
                r_hops <= '0;
            end
            tplq_pkg::DP_LCA_RDV: r_ent_u <= r_node_q;
            tplq_pkg::DP_LCA_CMP: begin
                if (r_ent_u.head == r_node_q.head) begin
                    r_lca <= early_node;
                    r_res <= $signed({1'b0, early_node});
                end else begin
                    r_u <= early_node;
                end
            end
            tplq_pkg::DP_LCA_HOP: begin
                r_v    <= r_node_q.parent[NW-1:0];
                r_hops <= r_hops + HW'(1);
            end
            tplq_pkg::DP_K_RDT: r_ent_s <= r_node_q;
            tplq_pkg::DP_K_RDX: r_ent_t <= r_node_q;
            tplq_pkg::DP_K_DIST: begin
                // walk from the far end when the target lies on the t side
                if (s_up < r_k) begin
                    r_ent_s <= r_ent_t;
                    r_k     <= path_len - r_k;
                end
                r_hops <= '0;
            end
            tplq_pkg::DP_K_HEAD: begin
                if (!(diff >= r_k)) begin
                    r_k <= r_k - diff - K_ONE;
                end
            end
            tplq_pkg::DP_K_NEXT: begin
                r_ent_s <= r_node_q;
                r_hops  <= r_hops + HW'(1);
            end
            tplq_pkg::DP_K_POS: r_res <= $signed({1'b0, r_pos_q});
            tplq_pkg::DP_FAIL:  r_res <= tplq_pkg::NODE_NONE;
            default: begin
            end
        endcase
    end

    assign o_result_node = r_res;

endmodule

/* tb/tplq_result_check.sv */
// ----------------------------------------------------------------------------
// tplq_result_check: result predictor and checker for the tree path query core
// Mirrors the node tables from every accepted load request, computes the LCA
// or k-th path vertex for every accepted query, and compares each result
// strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tplq_result_check #(
    parameter int MAX_NODES = tplq_pkg::MAX_NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [tplq_pkg::FUNC_W-1:0]       i_func,
    input  logic [tplq_pkg::NODE_W-1:0]       i_node_a,
    input  logic [tplq_pkg::NODE_W-1:0]       i_node_b,
    input  logic [tplq_pkg::NODE_W-1:0]       i_step_count,
    input  logic signed [tplq_pkg::PAR_W-1:0] i_parent_node,
    input  logic [tplq_pkg::NODE_W-1:0]       i_chain_head,
    input  logic [tplq_pkg::NODE_W-1:0]       i_node_depth,
    input  logic [tplq_pkg::NODE_W-1:0]       i_visit_position,
    input  logic                              i_result_valid,
    input  logic signed [tplq_pkg::PAR_W-1:0] i_result_node,
    output int                                o_fail_count,
    output int                                o_pending
);

    int parent_of [MAX_NODES];
    int head_of   [MAX_NODES];
    int depth_of  [MAX_NODES];
    int pos_of    [MAX_NODES];
    int node_at   [MAX_NODES];

    logic signed [tplq_pkg::PAR_W-1:0] expected_nodes [$];
    int errors = 0;

    function automatic bit in_range(int n);
        return n >= 0 && n < MAX_NODES;
    endfunction

    // Climb from the node later in preorder until both share a chain.
    function automatic int common_ancestor(int u, int v);
        int swap_node;
        for (int hops = 0; hops <= MAX_NODES; hops++) begin
            if (!in_range(u) || !in_range(v))
                return -1;
            if (pos_of[u] > pos_of[v]) begin
                swap_node = u;
                u = v;
                v = swap_node;
            end
            if (head_of[u] == head_of[v])
                return u;
            if (!in_range(head_of[v]))
                return -1;
            v = parent_of[head_of[v]];
            if (v < 0)
                return -1;
        end
        return -1;
    endfunction

    function automatic int path_vertex(int s, int t, int k);
        int top;
        int span;
        int hs;
        int pos;
        int hops;
        top = common_ancestor(s, t);
        if (top < 0)
            return -1;
        span = depth_of[s] + depth_of[t] - 2 * depth_of[top];
        if (span < k)
            return -1;
        // target lies on the t side: walk up from t instead
        if (depth_of[s] - depth_of[top] < k) begin
            s = t;
            k = span - k;
        end
        hs = head_of[s];
        hops = 0;
        while (1'b1) begin
            if (hops > MAX_NODES || !in_range(hs))
                return -1;
            if (depth_of[s] - depth_of[hs] >= k)
                break;
            k -= depth_of[s] - depth_of[hs] + 1;
            s = parent_of[hs];
            if (!in_range(s))
                return -1;
            hs = head_of[s];
            hops++;
        end
        pos = pos_of[s] - k;
        if (!in_range(pos))
            return -1;
        return node_at[pos];
    endfunction

    always @(posedge i_clk) begin
        logic signed [tplq_pkg::PAR_W-1:0] want;
        int answer;
        if (i_rst_n) begin
            if (i_result_valid === 1'b1) begin
                if (expected_nodes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got %0d",
                             $time, i_result_node);
                end else begin
                    want = expected_nodes.pop_front();
                    if (i_result_node !== want) begin
                        errors++;
                        $display("%0t: result_node mismatch: expected %0d, got %0d",
                                 $time, want, i_result_node);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                case (i_func)
                    tplq_pkg::FUNC_LOAD: begin
                        if (i_node_a < MAX_NODES) begin
                            parent_of[i_node_a] = int'(i_parent_node);
                            head_of[i_node_a]   = int'(i_chain_head);
                            depth_of[i_node_a]  = int'(i_node_depth);
                            pos_of[i_node_a]    = int'(i_visit_position);
                        end
                        if (i_visit_position < MAX_NODES)
                            node_at[i_visit_position] = int'(i_node_a);
                    end
                    tplq_pkg::FUNC_LCA: begin
                        answer = common_ancestor(int'(i_node_a), int'(i_node_b));
                        expected_nodes.push_back(answer[tplq_pkg::PAR_W-1:0]);
                    end
                    tplq_pkg::FUNC_KTH: begin
                        answer = path_vertex(int'(i_node_a), int'(i_node_b),
                                             int'(i_step_count));
                        expected_nodes.push_back(answer[tplq_pkg::PAR_W-1:0]);
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_nodes.size();
        o_fail_count <= errors;
    end

endmodule

/* tb/tree_path_lca_query_core_tb.sv */
// ----------------------------------------------------------------------------
// tree_path_lca_query_core_tb: top-level testbench for the tree path query core
// Fills every node table entry with a 1024-node path, runs directed LCA and
// k-th vertex queries on extremes and fault cases, then loads random
// heavy-light decomposed trees and queries them with random pacing.
// ----------------------------------------------------------------------------
module tree_path_lca_query_core_tb;

    localparam int                          NODES       = tplq_pkg::MAX_NODES_DEF;
    localparam logic [tplq_pkg::FUNC_W-1:0] FUNC_SPARE  = 2'd3;
    localparam int                          STALL_LIMIT = 40000;
    localparam int                          ITEM_TARGET = 1850;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [tplq_pkg::FUNC_W-1:0]       i_func;
    logic [tplq_pkg::NODE_W-1:0]       i_node_a;
    logic [tplq_pkg::NODE_W-1:0]       i_node_b;
    logic [tplq_pkg::NODE_W-1:0]       i_step_count;
    logic signed [tplq_pkg::PAR_W-1:0] i_parent_node;
    logic [tplq_pkg::NODE_W-1:0]       i_chain_head;
    logic [tplq_pkg::NODE_W-1:0]       i_node_depth;
    logic [tplq_pkg::NODE_W-1:0]       i_visit_position;
    logic                              o_result_valid;
    logic signed [tplq_pkg::PAR_W-1:0] o_result_node;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int items_sent  = 0;
    bit no_gaps     = 1'b0;

    // scratch for random tree generation, indexed by generation order
    int up        [NODES];
    int sz        [NODES];
    int heavy     [NODES];
    int first_kid [NODES];
    int next_kid  [NODES];
    int hd        [NODES];
    int dep       [NODES];
    int ord       [NODES];
    int label     [NODES];
    int pool      [NODES];
    int stk       [NODES];

    tree_path_lca_query_core #(
        .MAX_NODES(NODES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_step_count     (i_step_count),
        .i_parent_node    (i_parent_node),
        .i_chain_head     (i_chain_head),
        .i_node_depth     (i_node_depth),
        .i_visit_position (i_visit_position),
        .o_result_valid   (o_result_valid),
        .o_result_node    (o_result_node)
    );

    tplq_result_check #(
        .MAX_NODES(NODES)
    ) u_result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_func           (i_func),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_step_count     (i_step_count),
        .i_parent_node    (i_parent_node),
        .i_chain_head     (i_chain_head),
        .i_node_depth     (i_node_depth),
        .i_visit_position (i_visit_position),
        .i_result_valid   (o_result_valid),
        .i_result_node    (o_result_node),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send(logic [tplq_pkg::FUNC_W-1:0] f, int a, int b, int k,
                        int par, int head, int depth, int pos);
        int gap;
        int junk;
        gap = pick_gap();
        if (gap > 0) begin
            // drop start and scramble the idle fields
            start         <= 1'b0;
            junk          = $urandom;
            i_func        <= junk[tplq_pkg::FUNC_W-1:0];
            junk          = $urandom;
            i_node_a      <= junk[tplq_pkg::NODE_W-1:0];
            junk          = $urandom;
            i_node_b      <= junk[tplq_pkg::NODE_W-1:0];
            junk          = $urandom;
            i_parent_node <= junk[tplq_pkg::PAR_W-1:0];
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_func           <= f;
        i_node_a         <= a[tplq_pkg::NODE_W-1:0];
        i_node_b         <= b[tplq_pkg::NODE_W-1:0];
        i_step_count     <= k[tplq_pkg::NODE_W-1:0];
        i_parent_node    <= par[tplq_pkg::PAR_W-1:0];
        i_chain_head     <= head[tplq_pkg::NODE_W-1:0];
        i_node_depth     <= depth[tplq_pkg::NODE_W-1:0];
        i_visit_position <= pos[tplq_pkg::NODE_W-1:0];
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    // Hold off requests until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic grow_tree(int n);
        int r;
        int v;
        int c;
        int cnt;
        int sp;
        int j;
        int tmp;
        int base;
        int dbase;
        int max_dep;
        up[0]  = -1;
        dep[0] = 0;
        max_dep = 0;
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 3);
            if (r == 0)
                up[i] = i - 1;
            else if (r == 1)
                up[i] = $urandom_range(i > 4 ? i - 4 : 0, i - 1);
            else
                up[i] = $urandom_range(0, i - 1);
            dep[i] = dep[up[i]] + 1;
            if (dep[i] > max_dep)
                max_dep = dep[i];
        end
        for (int i = 0; i < n; i++) begin
            sz[i]        = 1;
            heavy[i]     = -1;
            first_kid[i] = -1;
        end
        for (int i = n - 1; i >= 1; i--) begin
            sz[up[i]] += sz[i];
            next_kid[i] = first_kid[up[i]];
            first_kid[up[i]] = i;
        end
        for (int i = 1; i < n; i++)
            if (heavy[up[i]] < 0 || sz[i] > sz[heavy[up[i]]])
                heavy[up[i]] = i;
        // heavy-first preorder: push the heavy child last so it pops next
        hd[0]  = 0;
        stk[0] = 0;
        sp     = 1;
        cnt    = 0;
        while (sp > 0) begin
            sp--;
            v = stk[sp];
            ord[v] = cnt;
            cnt++;
            for (c = first_kid[v]; c >= 0; c = next_kid[c])
                if (c != heavy[v]) begin
                    hd[c]   = c;
                    stk[sp] = c;
                    sp++;
                end
            if (heavy[v] >= 0) begin
                hd[heavy[v]] = hd[v];
                stk[sp] = heavy[v];
                sp++;
            end
        end
        for (int i = 0; i < n; i++) begin
            j = $urandom_range(i, NODES - 1);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
            label[i] = pool[i];
        end
        base  = $urandom_range(0, NODES - n);
        dbase = $urandom_range(0, (NODES - 1) - max_dep);
        // load in random order
        for (int i = 0; i < n; i++)
            stk[i] = i;
        for (int i = 0; i < n; i++) begin
            j = $urandom_range(i, n - 1);
            tmp = stk[i];
            stk[i] = stk[j];
            stk[j] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            v = stk[i];
            send(tplq_pkg::FUNC_LOAD, label[v], $urandom, $urandom,
                 v == 0 ? -1 : label[up[v]], label[hd[v]],
                 dbase + dep[v], base + ord[v]);
        end
    endtask

    task automatic query_tree(int n);
        int x;
        int y;
        int r;
        int q;
        q = n / 2 + $urandom_range(2, 20);
        for (int i = 0; i < q; i++) begin
            x = $urandom_range(0, n - 1);
            y = $urandom_range(0, n - 1);
            r = $urandom_range(0, 99);
            if (r < 44)
                send(tplq_pkg::FUNC_LCA, label[x], label[y], $urandom, $urandom,
                     $urandom, $urandom, $urandom);
            else if (r < 88)
                send(tplq_pkg::FUNC_KTH, label[x], label[y],
                     $urandom_range(0, dep[x] + dep[y] + 1),
                     $urandom, $urandom, $urandom, $urandom);
            else if (r < 93)
                send(r < 90 ? tplq_pkg::FUNC_LCA : tplq_pkg::FUNC_KTH,
                     $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
            else if (r < 99)
                send(FUNC_SPARE, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
            else
                // corrupt one entry of the live tree
                send(tplq_pkg::FUNC_LOAD, label[x], $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int n;
        int r;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_func           = '0;
        i_node_a         = '0;
        i_node_b         = '0;
        i_step_count     = '0;
        i_parent_node    = '0;
        i_chain_head     = '0;
        i_node_depth     = '0;
        i_visit_position = '0;
        for (int i = 0; i < NODES; i++)
            pool[i] = i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one long chain covers every table entry
        for (int i = 0; i < NODES; i++)
            send(tplq_pkg::FUNC_LOAD, i, 0, 0, i == 0 ? -1 : i - 1, 0, i, i);

        send(tplq_pkg::FUNC_LCA, 0, 1023, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_LCA, 1023, 1023, 1023, -1, 1023, 1023, 1023);
        send(tplq_pkg::FUNC_LCA, 1023, 512, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 0, 1023, 1023, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 1023, 0, 1023, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 1023, 0, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 5, 9, 5, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 700, 300, 400, 0, 0, 0, 0);
        send(FUNC_SPARE, 1023, 1023, 1023, -1, 1023, 1023, 1023);
        // detached root: climbing runs off the top
        send(tplq_pkg::FUNC_LOAD, 1000, 0, 0, -1, 1000, 0, 1000);
        send(tplq_pkg::FUNC_LCA, 1000, 999, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_LCA, 999, 1000, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 1000, 5, 1, 0, 0, 0, 0);
        // self-parented chain heads: climbing never terminates on its own
        send(tplq_pkg::FUNC_LOAD, 900, 0, 0, 900, 900, 900, 900);
        send(tplq_pkg::FUNC_LOAD, 901, 0, 0, 901, 901, 901, 901);
        send(tplq_pkg::FUNC_LCA, 900, 901, 0, 0, 0, 0, 0);
        send(tplq_pkg::FUNC_KTH, 901, 900, 3, 0, 0, 0, 0);
        drain();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                n = $urandom_range(2, 40);
            else if (r < 96)
                n = $urandom_range(41, 200);
            else
                n = $urandom_range(201, 700);
            // keep the last trees small so the item count lands near the target
            if (n > (ITEM_TARGET - items_sent) / 2)
                n = (ITEM_TARGET - items_sent) / 2;
            if (n < 2)
                n = 2;
            no_gaps = ($urandom_range(0, 3) == 0);
            grow_tree(n);
            query_tree(n);
            if ($urandom_range(0, 2) == 0)
                drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
